// ===== src/constant_color_alpha_blender_unit_assert.svh =====
`ifndef CONSTANT_COLOR_ALPHA_BLENDER_UNIT_ASSERT_SVH
`define CONSTANT_COLOR_ALPHA_BLENDER_UNIT_ASSERT_SVH

// ante implies cons, checked at every clock edge outside reset
`define CBL_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// expr holds at every clock edge outside reset
`define CBL_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

`endif

// ===== src/cbl_pkg.sv =====
`timescale 1ns / 1ps

package cbl_pkg;

   localparam int ChanNum = 3;

   typedef logic [1:0] fmt_type;

   localparam fmt_type FMT_RGB332   = 2'd0;
   localparam fmt_type FMT_RGB565   = 2'd1;
   localparam fmt_type FMT_RGB888   = 2'd2;
   localparam fmt_type FMT_XRGB8888 = 2'd3;

   localparam fmt_type    FMT_RESET  = FMT_XRGB8888;
   localparam logic [31:0] FILL_RESET = 32'h0000_0000;

   typedef enum logic [0:0] {
      CSR_PIXEL_FORMAT = 1'b0,
      CSR_FILL_COLOR   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] dest_pixel;
      logic        end_of_run;
   } req_type;

   typedef struct packed {
      logic [31:0] blended_pixel;
      logic        run_done;
   } rsp_type;

   // after unpack: channel 2 red, 1 green, 0 blue
   typedef struct packed {
      logic                      valid;
      fmt_type                   fmt;
      logic                      end_of_run;
      logic [7:0]                alpha;
      logic [ChanNum-1:0][7:0]   bg;
      logic [ChanNum-1:0][8:0]   diff;
   } unpack_type;

   // after multiply
   typedef struct packed {
      logic                      valid;
      fmt_type                   fmt;
      logic                      end_of_run;
      logic [ChanNum-1:0][7:0]   bg;
      logic [ChanNum-1:0][16:0]  prod;
   } mul_type;

endpackage

// ===== src/cbl_unpack.sv =====
`timescale 1ns / 1ps

module cbl_unpack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cbl_pkg::req_type     in_word,
   input  cbl_pkg::fmt_type     fmt,
   input  logic [31:0]          fill_color,
   output cbl_pkg::unpack_type  out_stage
);
   import cbl_pkg::*;

   logic [ChanNum-1:0][7:0] fg;
   unpack_type              stage_in;
   unpack_type              stage_ff;

   always_comb begin
      stage_in            = '0;
      stage_in.valid      = in_valid;
      stage_in.fmt        = fmt;
      stage_in.end_of_run = in_word.end_of_run;
      fg                  = '0;
      case (fmt)
         FMT_RGB332: begin
            stage_in.alpha = {5'b0, fill_color[31:29]};
            stage_in.bg[2] = {5'b0, in_word.dest_pixel[7:5]};
            stage_in.bg[1] = {5'b0, in_word.dest_pixel[4:2]};
            stage_in.bg[0] = {6'b0, in_word.dest_pixel[1:0]};
            fg[2]          = {5'b0, fill_color[7:5]};
            fg[1]          = {5'b0, fill_color[4:2]};
            fg[0]          = {6'b0, fill_color[1:0]};
         end
         FMT_RGB565: begin
            stage_in.alpha = {3'b0, fill_color[31:27]};
            stage_in.bg[2] = {3'b0, in_word.dest_pixel[15:11]};
            stage_in.bg[1] = {2'b0, in_word.dest_pixel[10:5]};
            stage_in.bg[0] = {3'b0, in_word.dest_pixel[4:0]};
            fg[2]          = {3'b0, fill_color[15:11]};
            fg[1]          = {2'b0, fill_color[10:5]};
            fg[0]          = {3'b0, fill_color[4:0]};
         end
         default: begin
            stage_in.alpha = fill_color[31:24];
            stage_in.bg[2] = in_word.dest_pixel[23:16];
            stage_in.bg[1] = in_word.dest_pixel[15:8];
            stage_in.bg[0] = in_word.dest_pixel[7:0];
            fg[2]          = fill_color[23:16];
            fg[1]          = fill_color[15:8];
            fg[0]          = fill_color[7:0];
         end
      endcase
      for (int c = 0; c < ChanNum; c++) begin
         stage_in.diff[c] = {1'b0, fg[c]} - {1'b0, stage_in.bg[c]};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign out_stage = stage_ff;

endmodule

// ===== src/cbl_mul.sv =====
`timescale 1ns / 1ps

module cbl_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  cbl_pkg::unpack_type  in_stage,
   output cbl_pkg::mul_type     out_stage
);
   import cbl_pkg::*;

   logic signed [17:0] prod_full [ChanNum];
   mul_type            stage_in;
   mul_type            stage_ff;

   always_comb begin
      stage_in            = '0;
      stage_in.valid      = in_stage.valid;
      stage_in.fmt        = in_stage.fmt;
      stage_in.end_of_run = in_stage.end_of_run;
      stage_in.bg         = in_stage.bg;
      for (int c = 0; c < ChanNum; c++) begin
         prod_full[c]     = $signed({1'b0, in_stage.alpha}) * $signed(in_stage.diff[c]);
         stage_in.prod[c] = prod_full[c][16:0];
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign out_stage = stage_ff;

endmodule

// ===== src/cbl_pack.sv =====
`timescale 1ns / 1ps

module cbl_pack (
   input  logic              clock,
   input  logic              reset,
   input  cbl_pkg::mul_type  in_stage,
   output logic              out_strobe,
   output cbl_pkg::rsp_type  out_word
);
   import cbl_pkg::*;

   logic signed [16:0]      quot [ChanNum];
   logic [ChanNum-1:0][7:0] chan;
   rsp_type                 word_in;
   rsp_type                 word_ff;
   logic                    strobe_ff;

   always_comb begin
      for (int c = 0; c < ChanNum; c++) begin
         case (in_stage.fmt)
            FMT_RGB332: quot[c] = $signed(in_stage.prod[c]) >>> 3;
            FMT_RGB565: quot[c] = $signed(in_stage.prod[c]) >>> 5;
            default:    quot[c] = $signed(in_stage.prod[c]) >>> 8;
         endcase
         chan[c] = in_stage.bg[c] + quot[c][7:0];
      end
      word_in.run_done = in_stage.end_of_run;
      case (in_stage.fmt)
         FMT_RGB332: word_in.blended_pixel = {24'b0, chan[2][2:0], chan[1][2:0], chan[0][1:0]};
         FMT_RGB565: word_in.blended_pixel = {16'b0, chan[2][4:0], chan[1][5:0], chan[0][4:0]};
         default:    word_in.blended_pixel = {8'b0, chan[2], chan[1], chan[0]};
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_stage.valid;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_word   = word_ff;

endmodule

// ===== src/constant_color_alpha_blender_unit.sv =====
// A word taken at a clock edge passes through the unpack, multiply and pack register
// stages in that order before it shows on rsp_strobe and rsp_word.
// Throughput: one word per cycle; busy stays low, the three stages are pipelined.
// Reset (synchronous, active high): clears stage valid bits, pixel_format to
// XRGB8888 and fill_color to zero; results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module constant_color_alpha_blender_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  cbl_pkg::req_type       req_word,
   output logic                   rsp_strobe,
   output cbl_pkg::rsp_type       rsp_word,
   input  logic                   csr_write_en,
   input  cbl_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);
   import cbl_pkg::*;

   fmt_type     pixel_format_ff;
   logic [31:0] fill_color_ff;
   unpack_type  unpack_stage;
   mul_type     mul_stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_RESET;
         fill_color_ff   <= FILL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[1:0];
            CSR_FILL_COLOR:   fill_color_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign busy = 1'b0;

   cbl_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_word    (req_word),
      .fmt        (pixel_format_ff),
      .fill_color (fill_color_ff),
      .out_stage  (unpack_stage)
   );

   cbl_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (unpack_stage),
      .out_stage (mul_stage)
   );

   cbl_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (mul_stage),
      .out_strobe (rsp_strobe),
      .out_word   (rsp_word)
   );

endmodule

// ===== src/cbl_checker.sv =====
`timescale 1ns / 1ps
`include "constant_color_alpha_blender_unit_assert.svh"

module cbl_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input cbl_pkg::req_type req_word,
   input logic             rsp_strobe,
   input cbl_pkg::rsp_type rsp_word
);

   `CBL_ASSERT_IMPLY(a_word_returns, clock, reset, start && !busy, ##3 rsp_strobe)
   `CBL_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_strobe, $past(start && !busy, 3))
   `CBL_ASSERT_IMPLY(a_run_done, clock, reset, rsp_strobe, rsp_word.run_done == $past(req_word.end_of_run, 3))
   `CBL_ASSERT_ALWAYS(a_top_byte_zero, clock, reset, !rsp_strobe || rsp_word.blended_pixel[31:24] == 8'h00)

endmodule

bind constant_color_alpha_blender_unit cbl_checker u_cbl_checker (.*);
